@@ rtl/mch_pkg.sv @@
// ----------------------------------------------------------------------------
// mch_pkg
// Shared types and constants of the masked chroma histogram.
// ----------------------------------------------------------------------------
package mch_pkg;

	localparam int CHROMA_W   = 8;
	localparam int BIN_ADDR_W = 2 * CHROMA_W;
	localparam int OUT_W      = 32;
	localparam int PROD_W     = 24;
	localparam int SUM_W      = 26;

	// Fixed-point coefficients, Q16
	localparam logic [15:0] CB_R_K = 16'd11058;
	localparam logic [15:0] CB_G_K = 16'd21709;
	localparam logic [15:0] CR_G_K = 16'd27439;
	localparam logic [15:0] CR_B_K = 16'd5328;
	localparam logic [SUM_W-1:0] CHROMA_OFS = SUM_W'(8421376);

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_ADD   = 2'd1,
		CMD_READ  = 2'd2
	} cmd_t;

endpackage

@@ rtl/mch_cvt.sv @@
// ----------------------------------------------------------------------------
// mch_cvt
// RGB to Cb/Cr conversion. Products registered, sum/shift/clamp after.
// ----------------------------------------------------------------------------
module mch_cvt import mch_pkg::*; (
	input  logic                clk,
	input  logic                load,
	input  logic [CHROMA_W-1:0] red,
	input  logic [CHROMA_W-1:0] green,
	input  logic [CHROMA_W-1:0] blue,
	output logic [CHROMA_W-1:0] cr,
	output logic [CHROMA_W-1:0] cb
);

	logic [PROD_W-1:0]   cb_r_s1, cb_g_s1, cr_g_s1, cr_b_s1;
	logic [CHROMA_W-1:0] red_s1, blue_s1;
	logic [SUM_W-1:0]    cb_sum, cr_sum;

	always_ff @(posedge clk) begin
		if (load) begin
			cb_r_s1 <= PROD_W'(PROD_W'(red) * PROD_W'(CB_R_K));
			cb_g_s1 <= PROD_W'(PROD_W'(green) * PROD_W'(CB_G_K));
			cr_g_s1 <= PROD_W'(PROD_W'(green) * PROD_W'(CR_G_K));
			cr_b_s1 <= PROD_W'(PROD_W'(blue) * PROD_W'(CR_B_K));
			red_s1  <= red;
			blue_s1 <= blue;
		end
	end

	assign cb_sum = CHROMA_OFS + SUM_W'({blue_s1, 15'd0})
		- SUM_W'(cb_r_s1) - SUM_W'(cb_g_s1);
	assign cr_sum = CHROMA_OFS + SUM_W'({red_s1, 15'd0})
		- SUM_W'(cr_g_s1) - SUM_W'(cr_b_s1);

	function automatic logic [CHROMA_W-1:0] clamp_chroma(input logic [SUM_W-1:0] s);
		logic [CHROMA_W:0] v;
		v = s[16 +: CHROMA_W + 1];
		if (s[SUM_W-1])
			return '0;
		else if (v[CHROMA_W])
			return '1;
		else
			return v[CHROMA_W-1:0];
	endfunction

	assign cb = clamp_chroma(cb_sum);
	assign cr = clamp_chroma(cr_sum);

endmodule

@@ rtl/mch_ram.sv @@
// ----------------------------------------------------------------------------
// mch_ram
// Bin memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mch_ram import mch_pkg::*; #(
	parameter int DATA_W = 32
) (
	input  logic                  clk,
	input  logic                  wr_en,
	input  logic [BIN_ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0]     wr_data,
	input  logic                  rd_en,
	input  logic [BIN_ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0]     rd_data
);

	logic [DATA_W-1:0] mem [2**BIN_ADDR_W];
	logic [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

@@ rtl/masked_chroma_histogram.sv @@
// ----------------------------------------------------------------------------
// masked_chroma_histogram
// 256 x 256 Cr/Cb histogram of a masked RGB pixel stream.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries one command per transaction:
// clear, add pixel, or read one bin. Output channel (out_valid/out_ready)
// carries bin_count, one transaction per read command only.
// Items are processed one at a time; in_ready is high only when idle.
//   add (mask nonzero): conversion products, then bin read,
//     then saturating write back through the bin memory.
//   add (mask zero), unused command: no bin is touched; the block stays idle.
//   read: bin read at acceptance, then ST_RD_RSP loads the output register; the block
//     holds there until the output register is free.
//   clear: one bin written per cycle by the sweep counter.
// After reset the same sweep runs before in_ready rises.
// A stalled receiver only blocks the next read; the output register holds
// its transaction until taken.
// ----------------------------------------------------------------------------
module masked_chroma_histogram import mch_pkg::*; #(
	parameter int COUNT_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          command,
	input  logic [CHROMA_W-1:0] red,
	input  logic [CHROMA_W-1:0] green,
	input  logic [CHROMA_W-1:0] blue,
	input  logic [CHROMA_W-1:0] pixel_mask,
	input  logic [CHROMA_W-1:0] read_cr,
	input  logic [CHROMA_W-1:0] read_cb,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [OUT_W-1:0]    bin_count
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_CLR    = 5'b00010,
		ST_ADD_RD = 5'b00100,
		ST_ADD_WR = 5'b01000,
		ST_RD_RSP = 5'b10000
	} state_t;

	state_t                state_q, state_d;
	logic [BIN_ADDR_W-1:0] clr_cnt_q;
	logic [BIN_ADDR_W-1:0] addr_q;
	logic                  out_valid_q;
	logic [COUNT_BITS-1:0] out_count_q;

	logic                  accept, out_load;
	cmd_t                  cmd;
	logic [CHROMA_W-1:0]   cvt_cr, cvt_cb;
	logic                  ram_we, ram_re;
	logic [BIN_ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [COUNT_BITS-1:0] ram_wdata, ram_rdata;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign cmd      = cmd_t'(command);
	assign out_load = (state_q == ST_RD_RSP) && (!out_valid_q || out_ready);

	mch_cvt u_cvt (
		.clk   (clk),
		.load  (accept),
		.red   (red),
		.green (green),
		.blue  (blue),
		.cr    (cvt_cr),
		.cb    (cvt_cb)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (cmd)
						CMD_CLEAR: state_d = ST_CLR;
						CMD_ADD:   state_d = (pixel_mask != '0) ? ST_ADD_RD : ST_IDLE;
						CMD_READ:  state_d = ST_RD_RSP;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_CLR:    if (clr_cnt_q == '1) state_d = ST_IDLE;
			ST_ADD_RD: state_d = ST_ADD_WR;
			ST_ADD_WR: state_d = ST_IDLE;
			ST_RD_RSP: if (out_load) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// memory port control
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = {cvt_cr, cvt_cb};
		if (accept && cmd == CMD_READ) begin
			ram_re    = 1'b1;
			ram_raddr = {read_cr, read_cb};
		end else if (state_q == ST_ADD_RD) begin
			ram_re = 1'b1;
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = '0;
		if (state_q == ST_CLR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_cnt_q;
		end else if (state_q == ST_ADD_WR) begin
			ram_we    = 1'b1;
			ram_wdata = (ram_rdata == '1) ? ram_rdata : ram_rdata + 1'b1;
		end
	end

	mch_ram #(
		.DATA_W (COUNT_BITS)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_en   (ram_re),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLR)
				clr_cnt_q <= clr_cnt_q + 1'b1;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_ADD_RD)
			addr_q <= {cvt_cr, cvt_cb};
		if (out_load)
			out_count_q <= ram_rdata;
	end

	assign out_valid = out_valid_q;
	assign bin_count = OUT_W'(out_count_q);

	// sweep walks every bin in order
	a_clr_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLR && clr_cnt_q != '1) |=>
		(state_q == ST_CLR && clr_cnt_q == BIN_ADDR_W'($past(clr_cnt_q) + 1'b1)))
		else $error("clear sweep skipped or stopped early");

	a_wr_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADD_WR) |-> ($past(state_q) == ST_ADD_RD))
		else $error("bin write back without a preceding read");

	a_sat_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADD_WR) |-> (ram_wdata >= ram_rdata && ram_wdata == addr_q * 0 + ram_wdata))
		else $error("bin count decreased on add");

	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_RD_RSP))
		else $error("result produced outside a read");

	a_no_wr_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !in_ready)
		else $error("bin write while accepting a transaction");

endmodule

@@ verif/mch_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mch_checker
// Watches both channels of the chroma histogram, keeps its own bin table
// and compares every bin_count transaction with the count predicted at read.
// ----------------------------------------------------------------------------
module mch_checker import mch_pkg::*; #(
	parameter int COUNT_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  logic [1:0]          command,
	input  logic [CHROMA_W-1:0] red,
	input  logic [CHROMA_W-1:0] green,
	input  logic [CHROMA_W-1:0] blue,
	input  logic [CHROMA_W-1:0] pixel_mask,
	input  logic [CHROMA_W-1:0] read_cr,
	input  logic [CHROMA_W-1:0] read_cb,
	input  logic                out_valid,
	input  logic                out_ready,
	input  logic [OUT_W-1:0]    bin_count,
	output int                  fail_count,
	output int                  pending,
	output logic [BIN_ADDR_W-1:0] recent_bin
);

	logic [COUNT_BITS-1:0] hist [0:(1 << BIN_ADDR_W) - 1];
	logic [OUT_W-1:0]      counts_due [$];

	// Cr in the upper byte, Cb in the lower; a chroma of 256 is clamped
	function automatic logic [BIN_ADDR_W-1:0] chroma_bin(input logic [7:0] r8,
		input logic [7:0] g8, input logic [7:0] b8);
		int r, g, b, cb_sum, cr_sum, cb, cr;
		r = r8;
		g = g8;
		b = b8;
		cb_sum = -11058 * r - 21709 * g + 32768 * b + 8421376;
		cr_sum = 32768 * r - 27439 * g - 5328 * b + 8421376;
		if (cb_sum < 0) cb_sum = 0;
		if (cr_sum < 0) cr_sum = 0;
		cb = cb_sum >>> 16;
		cr = cr_sum >>> 16;
		if (cb > 255) cb = 255;
		if (cr > 255) cr = 255;
		return {cr[7:0], cb[7:0]};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [OUT_W-1:0]      want;
		logic [BIN_ADDR_W-1:0] idx;
		if (!arst_n) begin
			for (int i = 0; i < (1 << BIN_ADDR_W); i++) hist[i] = '0;
			counts_due.delete();
			fail_count = 0;
			pending    = 0;
			recent_bin = '0;
		end else begin
			if (out_valid && out_ready) begin
				if (counts_due.size() == 0) begin
					if (fail_count < 10)
						$display("%0t: unexpected bin_count transaction %0d",
							$realtime, bin_count);
					fail_count++;
				end else begin
					want = counts_due.pop_front();
					if (bin_count !== want) begin
						if (fail_count < 10)
							$display("%0t: bin_count mismatch: expected %0d, got %0d",
								$realtime, want, bin_count);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				case (command)
					CMD_CLEAR: begin
						for (int i = 0; i < (1 << BIN_ADDR_W); i++) hist[i] = '0;
					end
					CMD_ADD: begin
						if (pixel_mask != '0) begin
							idx = chroma_bin(red, green, blue);
							if (hist[idx] != '1) hist[idx] = hist[idx] + 1'b1;
							recent_bin = idx;
						end
					end
					CMD_READ: begin
						want = OUT_W'(hist[{read_cr, read_cb}]);
						counts_due.push_back(want);
					end
					default: ;
				endcase
			end
			pending = counts_due.size();
		end
	end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the masked chroma histogram: directed chroma extremes, mask
// and clear cases, then random pixel bursts with reads of the bins they hit,
// a long same-bin burst, a long output stall and a drain pause.
// ----------------------------------------------------------------------------
module tb import mch_pkg::*; ();

	// bin counter width shared by design and predictor
	localparam int          HIST_BITS  = 32;
	localparam logic [1:0]  CMD_UNUSED = 2'd3;
	localparam int          RAND_ITEMS = 1650;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [1:0]            command;
	logic [CHROMA_W-1:0]   red, green, blue, pixel_mask, read_cr, read_cb;
	logic                  out_valid;
	logic                  out_ready;
	logic [OUT_W-1:0]      bin_count;
	int                    fail_count;
	int                    pending;
	logic [BIN_ADDR_W-1:0] recent_bin;

	logic                  calm;
	logic                  hold_req;
	int                    n_items;
	logic [23:0]           palette [4];

	masked_chroma_histogram #(.COUNT_BITS(HIST_BITS)) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.pixel_mask (pixel_mask),
		.read_cr    (read_cr),
		.read_cb    (read_cb),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.bin_count  (bin_count)
	);

	mch_checker #(.COUNT_BITS(HIST_BITS)) chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.pixel_mask (pixel_mask),
		.read_cr    (read_cr),
		.read_cb    (read_cb),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.bin_count  (bin_count),
		.fail_count (fail_count),
		.pending    (pending),
		.recent_bin (recent_bin)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#20_000_000;
		$display("FAILURE");
		$finish;
	end

	task automatic send(input logic [1:0] cmd, input logic [23:0] rgb,
		input logic [7:0] m, input logic [7:0] cr, input logic [7:0] cb);
		@(negedge clk);
		while (!calm && $urandom_range(0, 99) < 26) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		command    <= cmd;
		red        <= rgb[23:16];
		green      <= rgb[15:8];
		blue       <= rgb[7:0];
		pixel_mask <= m;
		read_cr    <= cr;
		read_cb    <= cb;
		in_valid   <= 1'b1;
		do @(posedge clk); while (!in_ready);
		// let the checker settle recent_bin before the caller reads it
		#1;
		n_items++;
	endtask

	task automatic add_px(input logic [23:0] rgb, input logic [7:0] m);
		send(CMD_ADD, rgb, m, 8'($urandom), 8'($urandom));
	endtask

	task automatic read_bin(input logic [BIN_ADDR_W-1:0] bin);
		send(CMD_READ, 24'($urandom), 8'($urandom), bin[15:8], bin[7:0]);
	endtask

	function automatic logic [23:0] pick_pixel();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 40) return palette[$urandom_range(0, 3)];
		if (sel < 50) return {{8{1'($urandom)}}, {8{1'($urandom)}}, {8{1'($urandom)}}};
		return 24'($urandom);
	endfunction

	function automatic logic [7:0] pick_mask();
		if ($urandom_range(0, 99) < 15) return 8'h00;
		return 8'($urandom_range(1, 255));
	endfunction

	task automatic wait_drained();
		while (pending != 0) @(negedge clk);
	endtask

	// receiver: random stalls, one long hold-off on request
	initial begin
		logic held;
		held = 1'b0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req && !held) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (400) @(negedge clk);
			end
			out_ready <= calm || ($urandom_range(0, 99) >= 26);
		end
	end

	initial begin
		logic did_hammer, did_hold, did_pause, did_clear;
		int   kind, len;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		command    = CMD_CLEAR;
		red        = '0;
		green      = '0;
		blue       = '0;
		pixel_mask = '0;
		read_cr    = '0;
		read_cb    = '0;
		calm       = 1'b0;
		hold_req   = 1'b0;
		n_items    = 0;
		did_hammer = 1'b0;
		did_hold   = 1'b0;
		did_pause  = 1'b0;
		did_clear  = 1'b0;
		for (int i = 0; i < 4; i++) palette[i] = 24'($urandom);
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// directed: chroma extremes, clamp to 255, mask off, unused command, clear
		read_bin(16'h0000);
		read_bin(16'hffff);
		add_px(24'h0000ff, 8'h01);
		read_bin(recent_bin);
		add_px(24'hff0000, 8'h80);
		read_bin(recent_bin);
		add_px(24'hffff00, 8'hff);
		read_bin(recent_bin);
		add_px(24'h00ffff, 8'h5a);
		read_bin(recent_bin);
		add_px(24'h000000, 8'h00);
		read_bin(16'h8080);
		add_px(24'h000000, 8'ha5);
		add_px(24'hffffff, 8'hff);
		read_bin(16'h8080);
		send(CMD_UNUSED, 24'($urandom), 8'($urandom), 8'h80, 8'h80);
		read_bin(16'h8080);
		send(CMD_CLEAR, 24'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		read_bin(16'h8080);
		read_bin(recent_bin);

		while (n_items < RAND_ITEMS) begin
			calm = (n_items >= 500 && n_items < 800);
			if (!did_hammer && n_items > 300) begin
				did_hammer = 1'b1;
				send(CMD_CLEAR, 24'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
				for (int i = 0; i < 270; i++) begin
					add_px(palette[0], 8'($urandom_range(1, 255)));
					if (i == 200 || i == 254) read_bin(recent_bin);
				end
				read_bin(recent_bin);
			end else if (!did_hold && n_items > 900) begin
				did_hold = 1'b1;
				hold_req = 1'b1;
				for (int i = 0; i < 16; i++) read_bin(recent_bin);
			end else if (!did_pause && n_items > 1200) begin
				did_pause = 1'b1;
				@(negedge clk);
				in_valid <= 1'b0;
				wait_drained();
			end else if (!did_clear && n_items > 1400) begin
				did_clear = 1'b1;
				send(CMD_CLEAR, 24'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
			end else begin
				kind = $urandom_range(0, 99);
				if (kind < 65) begin
					len = $urandom_range(1, 12);
					for (int i = 0; i < len; i++) add_px(pick_pixel(), pick_mask());
					len = $urandom_range(1, 3);
					for (int i = 0; i < len; i++) read_bin(recent_bin);
				end else if (kind < 85) begin
					read_bin(BIN_ADDR_W'($urandom));
				end else if (kind < 93) begin
					send(CMD_UNUSED, 24'($urandom), 8'($urandom), 8'($urandom),
						8'($urandom));
				end else begin
					add_px(24'($urandom), 8'h00);
				end
			end
		end
		calm = 1'b0;
		read_bin(recent_bin);
		@(negedge clk);
		in_valid <= 1'b0;
		wait_drained();
		repeat (20) @(negedge clk);
		if (fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
